### rtl/assert_macros.svh
// Assertion macros shared by the pulse drive timer bank RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset
`define PDT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pdt assertion failed");

// Check that an expression never holds outside reset
`define PDT_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("pdt forbidden condition seen");

`else

`define PDT_ASSERT(label, clk, rst_n, prop)
`define PDT_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

### rtl/pdt_pkg.sv
// Shared types and constants of the pulse drive timer bank.
// No dependencies; imported by every module of the block.
package pdt_pkg;

    localparam int MOTORS_DEF     = 8;
    localparam int COUNT_BITS_DEF = 16;
    localparam int MASK_BITS      = 8;
    localparam int CFG_BITS       = 16;
    localparam int OP_BITS        = 2;
    localparam int INDEX_BITS     = 3;
    localparam int IN_DATA_BITS   = 8;
    localparam int OUT_DATA_BITS  = 16;
    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;

    typedef enum logic [OP_BITS-1:0] {
        OP_ARM  = 2'b00,
        OP_FIRE = 2'b01,
        OP_TICK = 2'b10
    } op_t;

    // Register selected by paddr[2]
    localparam logic REG_READY_COUNT = 1'b0;
    localparam logic REG_DRIVE_COUNT = 1'b1;

    localparam logic [CFG_BITS-1:0] READY_COUNT_RST = 16'd100;
    localparam logic [CFG_BITS-1:0] DRIVE_COUNT_RST = 16'd50;

    typedef struct packed {
        logic [CFG_BITS-1:0] ready_count;
        logic [CFG_BITS-1:0] drive_count;
    } cfg_t;

    typedef struct packed {
        logic busy_next;
        logic leave;
        logic drive;
    } lane_status_t;

endpackage

### rtl/pdt_cfg.sv
// APB register file holding the ready and drive counter load values.
// Depends on pdt_pkg.
module pdt_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pdt_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [pdt_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [pdt_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready,
    output pdt_pkg::cfg_t                        cfg
);
    import pdt_pkg::*;

    logic [CFG_BITS-1:0] ready_count_reg;
    logic [CFG_BITS-1:0] ready_count_next;
    logic [CFG_BITS-1:0] drive_count_reg;
    logic [CFG_BITS-1:0] drive_count_next;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        ready_count_next = ready_count_reg;
        drive_count_next = drive_count_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_READY_COUNT: ready_count_next = pwdata[CFG_BITS-1:0];
                REG_DRIVE_COUNT: drive_count_next = pwdata[CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_count_reg <= READY_COUNT_RST;
            drive_count_reg <= DRIVE_COUNT_RST;
        end
        else
        begin
            ready_count_reg <= ready_count_next;
            drive_count_reg <= drive_count_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_READY_COUNT: prdata = APB_DATA_BITS'(ready_count_reg);
            REG_DRIVE_COUNT: prdata = APB_DATA_BITS'(drive_count_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.ready_count = ready_count_reg;
    assign cfg.drive_count = drive_count_reg;

endmodule

### rtl/pdt_lane.sv
// One motor timer: busy flag, ready counter and drive counter.
// Depends on pdt_pkg.
module pdt_lane #(
    parameter int COUNT_BITS = pdt_pkg::COUNT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire_en,
    input  logic                  tick_en,
    input  pdt_pkg::cfg_t         cfg,
    output pdt_pkg::lane_status_t status
);
    import pdt_pkg::*;

    logic                  busy_reg;
    logic                  busy_next;
    logic [COUNT_BITS-1:0] ready_cnt_reg;
    logic [COUNT_BITS-1:0] ready_cnt_next;
    logic [COUNT_BITS-1:0] drive_cnt_reg;
    logic [COUNT_BITS-1:0] drive_cnt_next;
    logic [COUNT_BITS-1:0] drive_cnt_dec;
    logic                  leave;
    logic                  drive;

    assign drive_cnt_dec = drive_cnt_reg - COUNT_BITS'(1);

    always_comb
    begin
        busy_next      = busy_reg;
        ready_cnt_next = ready_cnt_reg;
        drive_cnt_next = drive_cnt_reg;
        leave          = 1'b0;
        drive          = 1'b0;
        if (fire_en)
        begin
            busy_next      = 1'b1;
            ready_cnt_next = COUNT_BITS'(cfg.ready_count);
            drive_cnt_next = COUNT_BITS'(cfg.drive_count);
        end
        else if (tick_en && busy_reg)
        begin
            if (ready_cnt_reg != '0)
            begin
                ready_cnt_next = ready_cnt_reg - COUNT_BITS'(1);
            end
            else
            begin
                busy_next = 1'b0;
                leave     = 1'b1;
            end
            // drive counter still runs on the tick that drops busy
            if (drive_cnt_reg != '0)
            begin
                drive_cnt_next = drive_cnt_dec;
                drive          = (drive_cnt_dec != '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    // counters are only looked at while busy, and every fire loads them
    always_ff @(posedge clk)
    begin
        ready_cnt_reg <= ready_cnt_next;
        drive_cnt_reg <= drive_cnt_next;
    end

    assign status.busy_next = busy_next;
    assign status.leave     = leave;
    assign status.drive     = drive;

endmodule

### rtl/pulse_drive_timer_bank_top.sv
// Top level of the pulse drive timer bank: arm bits, motor lanes, result register.
// Depends on pdt_pkg, pdt_cfg, pdt_lane and assert_macros.svh.

// Bank of MOTORS pulse timers driven by a stream of arm, fire and tick
// transactions. Each accepted transaction gives exactly one result, held in a
// single output register from the cycle after acceptance; all motors update in
// parallel, so one transaction is taken per clock while not stalled. s_tready
// is high while the output register is empty or being drained in the same
// cycle. Counter load values come from two APB registers (ready_count at 0x0,
// drive_count at 0x4) and should be written only while the bank is idle.
`include "assert_macros.svh"

module pulse_drive_timer_bank_top #(
    parameter int MOTORS     = pdt_pkg::MOTORS_DEF,
    parameter int COUNT_BITS = pdt_pkg::COUNT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // s_tdata: [2:0] motor_index, [7:3] zero
    input  logic [pdt_pkg::IN_DATA_BITS-1:0]     s_tdata,
    // s_tuser: [1:0] operation
    input  logic [pdt_pkg::OP_BITS-1:0]          s_tuser,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // m_tdata: [7:0] drive_mask, [15:8] ready_mask
    output logic [pdt_pkg::OUT_DATA_BITS-1:0]    m_tdata,
    // m_tuser: [0] drive_update
    output logic                                 m_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pdt_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [pdt_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [pdt_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready
);
    import pdt_pkg::*;

    cfg_t                   cfg;
    op_t                    op;
    logic [INDEX_BITS-1:0]  motor_index;
    logic                   accept;
    logic [MOTORS-1:0]      armed_reg;
    logic [MOTORS-1:0]      armed_next;
    logic [MOTORS-1:0]      arm_set;
    logic [MOTORS-1:0]      fire_en;
    logic                   tick_en;
    lane_status_t           status [MOTORS];
    logic [MOTORS-1:0]      busy_vec;
    logic [MOTORS-1:0]      leave_vec;
    logic [MOTORS-1:0]      drive_vec;
    logic                   res_update;
    logic [MASK_BITS-1:0]   res_drive;
    logic [MASK_BITS-1:0]   res_ready;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_update_reg;
    logic [MASK_BITS-1:0]   out_drive_reg;
    logic [MASK_BITS-1:0]   out_ready_reg;

    pdt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign op          = op_t'(s_tuser);
    assign motor_index = s_tdata[INDEX_BITS-1:0];
    assign s_tready    = !out_valid_reg || m_tready;
    assign accept      = s_tvalid && s_tready;
    assign tick_en     = accept && (op == OP_TICK);

    for (genvar m = 0; m < MOTORS; m++)
    begin : g_lane
        // an index beyond the bank matches no lane and is dropped
        assign arm_set[m] = (motor_index == INDEX_BITS'(m));
        assign fire_en[m] = accept && (op == OP_FIRE) && armed_reg[m];

        pdt_lane #(
            .COUNT_BITS (COUNT_BITS)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .fire_en (fire_en[m]),
            .tick_en (tick_en),
            .cfg     (cfg),
            .status  (status[m])
        );

        assign busy_vec[m]  = status[m].busy_next;
        assign leave_vec[m] = status[m].leave;
        assign drive_vec[m] = status[m].drive;
    end

    always_comb
    begin
        armed_next = armed_reg;
        if (accept)
        begin
            case (op)
                OP_ARM:  armed_next = armed_reg | arm_set;
                OP_FIRE: armed_next = '0;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        // motors beyond the bank report zero
        res_ready               = '0;
        res_ready[MOTORS-1:0]   = ~busy_vec;
        case (op)
            OP_FIRE:
            begin
                res_update = 1'b1;
                res_drive  = MASK_BITS'(armed_reg);
            end
            OP_TICK:
            begin
                res_update = (|leave_vec) || (|drive_vec);
                res_drive  = MASK_BITS'(drive_vec);
            end
            default:
            begin
                res_update = 1'b0;
                res_drive  = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            armed_reg     <= armed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the result until the downstream side takes it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_update_reg <= res_update;
            out_drive_reg  <= res_drive;
            out_ready_reg  <= res_ready;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_update_reg;
    assign m_tdata  = {out_ready_reg, out_drive_reg};

    `PDT_ASSERT(a_fire_clears_armed, clk, rst_n,
        (accept && op == OP_FIRE) |=> (armed_reg == '0))
    `PDT_ASSERT(a_fire_gives_update, clk, rst_n,
        (accept && op == OP_FIRE) |=> (out_valid_reg && out_update_reg))
    `PDT_ASSERT(a_no_mask_without_update, clk, rst_n,
        (out_valid_reg && !out_update_reg) |-> (out_drive_reg == '0))
    `PDT_ASSERT_NEVER(a_stall_only_when_full, clk, rst_n,
        !s_tready && !out_valid_reg)

endmodule
